/* design/m3i_pkg.sv */
// Shared types and constants of the 3x3 matrix inverse core.
// Depends on nothing; the core, front end, divider lanes and testbench import it.
package m3i_pkg;

   // Widths of the fixed-point values inside the datapath.
   localparam int EntryW = 16;   // Q8.8 input entry
   localparam int CofW   = 33;   // signed cofactor, Q17.16
   localparam int MagW   = 32;   // cofactor magnitude
   localparam int DetW   = 50;   // signed determinant, scale 2^-24
   localparam int DivW   = 49;   // determinant magnitude
   localparam int QuotW  = 32;   // Q16.16 result

   // Pipeline depths.
   localparam int FrontDepth = 3;
   localparam int DivSteps   = 32;
   localparam int LaneDepth  = DivSteps + 1;
   localparam int PipeDepth  = FrontDepth + LaneDepth;

   localparam int NumEntries = 9;

   // What the cofactor front end hands to the divider lanes.
   typedef struct packed {
      logic [NumEntries-1:0][MagW-1:0] cof_mag;
      logic [NumEntries-1:0]           cof_neg;
      logic [DivW-1:0]                 det_mag;
      logic                            det_neg;
      logic                            singular;
   } front_type;

endpackage

/* design/m3i_if.sv */
// Valid/ready channel interfaces for the matrix item and the inverse item.
// Depends on nothing.
interface m3i_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

   modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   input ready);
   modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   output ready);
endinterface

interface m3i_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
   logic               singular;

   modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                   inv20, inv21, inv22, singular, input ready);
   modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                   inv20, inv21, inv22, singular, output ready);
endinterface

/* design/matrix3x3_inverse_core.sv */
// Each item is a 3x3 matrix of signed Q8.8 entries; the result item is its
// inverse in signed Q16.16, truncated toward zero and saturated, plus a
// singular flag that zeroes all entries when the determinant is zero. A
// new item can be taken every cycle while the pipeline is not stalled;
// three stages form cofactors and determinant, then nine parallel divider
// lanes spend one stage per quotient bit. The
// output register holds a waiting result while the pipeline keeps taking
// items until the item at its end has nowhere to go.
module matrix3x3_inverse_core (
   input  logic      clock,
   input  logic      reset,
   m3i_req_if.sink   req_chan,
   m3i_rsp_if.source rsp_chan
);
   import m3i_pkg::*;

   logic                            en;
   logic [NumEntries-1:0][15:0]     mat;
   front_type                       front;
   logic [PipeDepth-1:0]            vld_ff, vld_in;
   logic [LaneDepth-1:0]            sing_ff;
   logic [QuotW-1:0]                lane_q [NumEntries];
   logic [QuotW-1:0]                out_ff [NumEntries];
   logic                            out_sing_ff;
   logic                            out_valid_ff, out_valid_in;

   // The pipeline advances unless a finished item is blocked by the output.
   assign en = !(out_valid_ff && !rsp_chan.ready && vld_ff[PipeDepth-1]);
   assign req_chan.ready = en;

   assign mat = {req_chan.a22, req_chan.a21, req_chan.a20,
                 req_chan.a12, req_chan.a11, req_chan.a10,
                 req_chan.a02, req_chan.a01, req_chan.a00};

   m3i_front u_front (
      .clock  (clock),
      .en     (en),
      .mat    (mat),
      .result (front)
   );

   // Lane i*3+j divides cofactor (j, i) by the determinant.
   for (genvar i = 0; i < 3; i++) begin : g_lane_row
      for (genvar j = 0; j < 3; j++) begin : g_lane_col
         m3i_div_lane u_lane (
            .clock   (clock),
            .en      (en),
            .num_mag (front.cof_mag[j*3+i]),
            .div_mag (front.det_mag),
            .neg     (front.cof_neg[j*3+i] ^ front.det_neg),
            .quot    (lane_q[i*3+j])
         );
      end
   end

   // Valid bits of the pipeline stages.
   assign vld_in = {vld_ff[PipeDepth-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Singular flag travels alongside the divider lanes.
   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff <= {sing_ff[LaneDepth-2:0], front.singular};
      end
   end

   // Merge the lanes into the output register.
   assign out_valid_in = (en && vld_ff[PipeDepth-1]) ? 1'b1 :
                         (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && vld_ff[PipeDepth-1]) begin
         for (int k = 0; k < NumEntries; k++) begin
            out_ff[k] <= sing_ff[LaneDepth-1] ? '0 : lane_q[k];
         end
         out_sing_ff <= sing_ff[LaneDepth-1];
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.inv00    = out_ff[0];
   assign rsp_chan.inv01    = out_ff[1];
   assign rsp_chan.inv02    = out_ff[2];
   assign rsp_chan.inv10    = out_ff[3];
   assign rsp_chan.inv11    = out_ff[4];
   assign rsp_chan.inv12    = out_ff[5];
   assign rsp_chan.inv20    = out_ff[6];
   assign rsp_chan.inv21    = out_ff[7];
   assign rsp_chan.inv22    = out_ff[8];
   assign rsp_chan.singular = out_sing_ff;

endmodule

/* design/m3i_front.sv */
// Cofactor and determinant front end: three pipeline stages.
// Depends on m3i_pkg.
module m3i_front (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic [m3i_pkg::NumEntries-1:0][15:0]  mat,
   output m3i_pkg::front_type                    result
);
   import m3i_pkg::*;

   logic signed [CofW-1:0]   cof_in  [NumEntries];
   logic signed [CofW-1:0]   cof_ff  [NumEntries];
   logic signed [CofW-1:0]   cof2_ff [NumEntries];
   logic [EntryW-1:0]        row_ff  [3];
   logic signed [DetW-1:0]   det_in;
   logic signed [DetW-1:0]   det_ff;
   front_type                result_in;
   front_type                result_ff;

   // Signed 2x2 minors, with the checkerboard sign applied.
   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         localparam int R1 = (r == 0) ? 1 : 0;
         localparam int R2 = (r == 2) ? 1 : 2;
         localparam int C1 = (c == 0) ? 1 : 0;
         localparam int C2 = (c == 2) ? 1 : 2;
         logic signed [31:0]     p0, p1;
         logic signed [CofW-1:0] minor;
         assign p0 = $signed(mat[R1*3+C1]) * $signed(mat[R2*3+C2]);
         assign p1 = $signed(mat[R1*3+C2]) * $signed(mat[R2*3+C1]);
         assign minor = CofW'(p0) - CofW'(p1);
         assign cof_in[r*3+c] = (((r + c) % 2) == 1) ? -minor : minor;
      end
   end

   // Determinant by expansion along the first row.
   logic signed [48:0] dp [3];
   for (genvar k = 0; k < 3; k++) begin : g_det
      assign dp[k] = $signed(row_ff[k]) * cof_ff[k];
   end
   assign det_in = DetW'(dp[0]) + DetW'(dp[1]) + DetW'(dp[2]);

   // Magnitudes and signs for the unsigned divider lanes.
   always_comb begin
      logic signed [DetW-1:0] dabs;
      logic signed [CofW-1:0] cabs;
      dabs = det_ff[DetW-1] ? -det_ff : det_ff;
      result_in.det_mag  = dabs[DivW-1:0];
      result_in.det_neg  = det_ff[DetW-1];
      result_in.singular = (det_ff == '0);
      for (int k = 0; k < NumEntries; k++) begin
         cabs = cof2_ff[k][CofW-1] ? -cof2_ff[k] : cof2_ff[k];
         result_in.cof_mag[k] = cabs[MagW-1:0];
         result_in.cof_neg[k] = cof2_ff[k][CofW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NumEntries; k++) begin
            cof_ff[k]  <= cof_in[k];
            cof2_ff[k] <= cof_ff[k];
         end
         for (int k = 0; k < 3; k++) begin
            row_ff[k] <= mat[k];
         end
         det_ff    <= det_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* design/m3i_div_lane.sv */
// One divider lane: pipelined restoring division, one quotient bit per
// stage, with Q16.16 saturation on the way out. Depends on m3i_pkg.
module m3i_div_lane (
   input  logic                         clock,
   input  logic                         en,
   input  logic [m3i_pkg::MagW-1:0]     num_mag,
   input  logic [m3i_pkg::DivW-1:0]     div_mag,
   input  logic                         neg,
   output logic [m3i_pkg::QuotW-1:0]    quot
);
   import m3i_pkg::*;

   localparam int HighW = MagW - 8;

   logic [DivW-1:0]  rem_ff  [LaneDepth];
   logic [QuotW-1:0] low_ff  [LaneDepth];
   logic [QuotW-1:0] q_ff    [LaneDepth];
   logic [DivW-1:0]  div_ff  [LaneDepth];
   logic             neg_ff  [LaneDepth];
   logic             ovf_ff  [LaneDepth];
   logic [DivW-1:0]  rem_in  [DivSteps];
   logic             bit_in  [DivSteps];
   logic [DivW-1:0]  high_in;

   // The dividend is num << 24; its bits 32 and up seed the remainder.
   assign high_in = {{(DivW-HighW){1'b0}}, num_mag[MagW-1:8]};

   // One restoring step per stage.
   for (genvar s = 0; s < DivSteps; s++) begin : g_step
      logic [DivW:0] trial;
      assign trial     = {rem_ff[s], low_ff[s][QuotW-1]};
      assign bit_in[s] = (trial >= {1'b0, div_ff[s]});
      assign rem_in[s] = bit_in[s] ? DivW'(trial - {1'b0, div_ff[s]}) : DivW'(trial);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= high_in;
         low_ff[0] <= {num_mag[7:0], 24'b0};
         q_ff[0]   <= '0;
         div_ff[0] <= div_mag;
         neg_ff[0] <= neg;
         ovf_ff[0] <= (high_in >= div_mag);
         for (int s = 0; s < DivSteps; s++) begin
            rem_ff[s+1] <= rem_in[s];
            low_ff[s+1] <= {low_ff[s][QuotW-2:0], 1'b0};
            q_ff[s+1]   <= {q_ff[s][QuotW-2:0], bit_in[s]};
            div_ff[s+1] <= div_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   // Sign and saturation to the signed 32-bit range.
   always_comb begin
      logic [QuotW-1:0] q;
      q = q_ff[LaneDepth-1];
      if (neg_ff[LaneDepth-1]) begin
         if (ovf_ff[LaneDepth-1] || (q > {1'b1, {(QuotW-1){1'b0}}})) begin
            quot = {1'b1, {(QuotW-1){1'b0}}};
         end else begin
            quot = -q;
         end
      end else begin
         if (ovf_ff[LaneDepth-1] || q[QuotW-1]) begin
            quot = {1'b0, {(QuotW-1){1'b1}}};
         end else begin
            quot = q;
         end
      end
   end

endmodule

/* design/m3i_checker.sv */
// Port-level checks of the 3x3 matrix inverse core, bound to the top level.
// Depends on nothing but the top level's ports.
module m3i_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_singular,
   input logic [31:0] inv00,
   input logic [31:0] inv11,
   input logic [31:0] inv22
);

   // A result waiting for the sink stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // A singular matrix shows zero on the diagonal of the inverse.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> inv00 == 0 && inv11 == 0 && inv22 == 0)
      else $error("singular item with nonzero entries");

   // Reset leaves no result on the output.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item present right after reset");

   // With the output free, the core always takes a new item.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("core stalled with an empty output");

   // No result is on the output when reset has just ended.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("unexpected state after reset");

endmodule

bind matrix3x3_inverse_core m3i_checker u_m3i_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_singular (rsp_chan.singular),
   .inv00        (rsp_chan.inv00),
   .inv11        (rsp_chan.inv11),
   .inv22        (rsp_chan.inv22)
);

/* sim/matrix3x3_inverse_core_tb.sv */
// Self-checking testbench of the 3x3 matrix inverse core.
// Depends on m3i_pkg, the m3i_req_if and m3i_rsp_if interfaces and the core.
module matrix3x3_inverse_core_tb;
   import m3i_pkg::*;

   // One expected inverse: nine Q16.16 entries and the singular flag.
   typedef struct {
      logic signed [31:0] inv [9];
      logic               singular;
   } inverse_type;

   typedef logic signed [15:0] matrix_type [9];

   // Holds the inverses still owed by the core and checks each arrival.
   class inverse_scoreboard;
      inverse_type owed [$];
      int          errors;

      // Exact (c << 24) / d, truncated toward zero, saturated to 32 bits.
      function automatic logic signed [31:0] divide_sat(longint c, longint d);
         logic signed [127:0] num;
         logic signed [127:0] q;
         num = 128'(c) <<< 24;
         q   = num / 128'(d);
         if (q > 128'sd2147483647) return 32'h7FFFFFFF;
         if (q < -128'sd2147483648) return 32'h80000000;
         return q[31:0];
      endfunction

      // Works out the inverse of an accepted matrix and queues it.
      function void note_matrix(matrix_type a);
         longint      m [3][3];
         longint      cof [3][3];
         longint      det;
         inverse_type e;
         int r1, r2, c1, c2;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               m[r][c] = a[r*3+c];
         for (int r = 0; r < 3; r++) begin
            r1 = (r == 0) ? 1 : 0;
            r2 = (r == 2) ? 1 : 2;
            for (int c = 0; c < 3; c++) begin
               c1 = (c == 0) ? 1 : 0;
               c2 = (c == 2) ? 1 : 2;
               cof[r][c] = m[r1][c1]*m[r2][c2] - m[r1][c2]*m[r2][c1];
               if ((r + c) % 2 == 1) cof[r][c] = -cof[r][c];
            end
         end
         det = m[0][0]*cof[0][0] + m[0][1]*cof[0][1] + m[0][2]*cof[0][2];
         e.singular = (det == 0);
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               e.inv[i*3+j] = (det == 0) ? 32'sd0 : divide_sat(cof[j][i], det);
         owed.push_back(e);
      endfunction

      // Compares an arriving inverse field by field with the oldest one owed.
      function void check_inverse(inverse_type got);
         inverse_type e;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result, singular=%0b inv00=%0d", $time,
                     got.singular, got.inv[0]);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (got.singular !== e.singular) begin
            $display("%0t: singular expected %0b actual %0b", $time, e.singular,
                     got.singular);
            errors++;
         end
         for (int k = 0; k < 9; k++)
            if (got.inv[k] !== e.inv[k]) begin
               $display("%0t: inv%0d%0d expected %0d actual %0d", $time, k / 3,
                        k % 3, e.inv[k], got.inv[k]);
               errors++;
            end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   cycle_count = 0;

   inverse_scoreboard board = new();

   m3i_req_if req_chan ();
   m3i_rsp_if rsp_chan ();

   matrix3x3_inverse_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #6 clock = ~clock;

   // Receiver: random stalls, results checked at the accepting edge.
   initial rsp_chan.ready = 1'b0;
   always @(posedge clock) begin
      inverse_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.inv = '{rsp_chan.inv00, rsp_chan.inv01, rsp_chan.inv02,
                     rsp_chan.inv10, rsp_chan.inv11, rsp_chan.inv12,
                     rsp_chan.inv20, rsp_chan.inv21, rsp_chan.inv22};
         got.singular = rsp_chan.singular;
         board.check_inverse(got);
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog on total cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Random 16-bit entry, often drawn from the extremes or small values.
   function automatic logic signed [15:0] rand_entry();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'($signed($urandom_range(8)) - 4);
         3: return 16'($signed($urandom_range(1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // Offers one matrix, holds it until accepted, then notes it.
   task automatic send_matrix(matrix_type a);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      {req_chan.a00, req_chan.a01, req_chan.a02} <= {a[0], a[1], a[2]};
      {req_chan.a10, req_chan.a11, req_chan.a12} <= {a[3], a[4], a[5]};
      {req_chan.a20, req_chan.a21, req_chan.a22} <= {a[6], a[7], a[8]};
      do @(posedge clock); while (!req_chan.ready);
      board.note_matrix(a);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
   endtask

   // Random matrices: mostly general, some singular by repeated or zero rows, some diagonal.
   task automatic send_random(int count);
      matrix_type a;
      for (int n = 0; n < count; n++) begin
         foreach (a[k]) a[k] = rand_entry();
         case ($urandom_range(9))
            0: for (int k = 0; k < 3; k++) a[3+k] = a[k];
            1: for (int k = 6; k < 9; k++) a[k] = 16'sd0;
            2: a = '{a[0], 16'sd0, 16'sd0, 16'sd0, a[4], 16'sd0, 16'sd0, 16'sd0, a[8]};
            default: ;
         endcase
         send_matrix(a);
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      {req_chan.a00, req_chan.a01, req_chan.a02} = '0;
      {req_chan.a10, req_chan.a11, req_chan.a12} = '0;
      {req_chan.a20, req_chan.a21, req_chan.a22} = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity, scaled identity, extremes, singular and saturating cases.
      send_matrix('{16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0,
                    16'sd0, 16'sd0, 16'sd256});
      send_matrix('{-16'sd512, 16'sd0, 16'sd0, 16'sd0, 16'sd128, 16'sd0,
                    16'sd0, 16'sd0, -16'sd256});
      send_matrix('{9{16'sd0}});
      send_matrix('{9{16'sh7FFF}});
      send_matrix('{9{16'sh8000}});
      send_matrix('{16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0,
                    16'sd0, 16'sd0, 16'sh8000});
      send_matrix('{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, 16'sh7FFF, 16'sh8000,
                    16'sh8000, 16'sd1, 16'sh7FFF});
      send_matrix('{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0,
                    16'sd0, 16'sd0, 16'sd1});
      send_matrix('{-16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0,
                    16'sd0, 16'sd0, 16'sd1});
      send_matrix('{16'sd256, 16'sd512, 16'sd768, 16'sd1024, 16'sd1280,
                    16'sd1536, 16'sd1792, 16'sd2048, 16'sd2304});
      send_matrix('{16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
                    16'sd0, 16'sd0, 16'sd256});
      send_matrix('{16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sh7FFF, 16'sh7FFE, 16'sd0,
                    16'sd0, 16'sd0, 16'sd1});
      send_matrix('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                    16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
      send_matrix('{16'sd2, 16'sd1, 16'sd1, 16'sd1, 16'sd3, 16'sd2,
                    16'sd1, 16'sd0, 16'sd0});
      send_matrix('{16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                    16'shFFFF, 16'shAAAA, 16'shFFFF, 16'sh5555});

      // Pause until every owed inverse has come back.
      wait_drained();

      // Random phases with different idling on each side.
      send_random(250);
      send_idle_pct = 82;
      send_random(150);
      send_idle_pct = 0;
      recv_stall_pct = 82;
      send_random(200);
      send_idle_pct = 20;
      recv_stall_pct = 20;
      send_random(200);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_random(100);

      wait_drained();
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
